[rtl/double_ended_queue_core_macros.svh]
// Assertion macros for the double-ended queue checker.
// Used by dqc_checker.sv; no other dependencies.
`ifndef DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH

// Property checked outside reset.
`define DQC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("deque check failed");

// Property checked on every edge, reset included.
`define DQC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("deque reset check failed");

`endif

[rtl/dqc_pkg.sv]
// Shared types and constants for the double-ended queue core.
// No dependencies; used by dqc_cell, the top level and the checker.
package dqc_pkg;

  localparam int DEPTH_DEFAULT = 32;
  localparam int DATA_W        = 32;
  localparam int CMD_W         = 3;
  localparam int STATUS_W      = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_DUMP       = 3'd4
  } cmd_t;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [DATA_W-1:0]   push_data;
  } cell_ctl_t;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

endpackage

[rtl/double_ended_queue_core.sv]
// Double-ended queue core: a row of DEPTH cells, front at cell 0.
// Push/pop: one transaction per cycle when output is free; result registered.
// Dump: one result per stored entry, one per cycle while output is free; the
//   occupied span rotates through cell 0; input is held until the dump ends.
// Empty dump, pops, pushes and unused codes give a single result.
// Reset (rst, synchronous) empties the queue; stored values are not cleared.
module double_ended_queue_core #(
  parameter int DEPTH = dqc_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  // input transaction
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [dqc_pkg::DATA_W-1:0]  s_tdata,   // [31:0] data_in
  input  logic [dqc_pkg::CMD_W-1:0]   s_tuser,   // [2:0] cmd
  // result transaction
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [dqc_pkg::DATA_W-1:0]  m_tdata,   // [31:0] data_out
  output logic [dqc_pkg::STATUS_W:0]  m_tuser,   // [0] has_value, [2:1] status
  output logic                        m_tlast    // last result of the command
);
  import dqc_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  // cell row
  logic [DATA_W-1:0] cell_data  [DEPTH];
  logic              cell_valid [DEPTH];
  cell_ctl_t         ctl;

  // control
  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  remain, remain_next;
  logic              full, empty;
  logic              out_free;
  logic              accept;
  cmd_t              cmd;

  // output register
  logic [DATA_W-1:0]   out_data, out_data_next;
  logic                out_has, out_has_next;
  logic [STATUS_W-1:0] out_status, out_status_next;
  logic                out_last, out_last_next;
  logic                load_out;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [DATA_W-1:0] l_data, r_data;
      logic              l_valid, r_valid;

      // cell 0 sees the pushed value on its left; the last cell sees an empty right
      if (gi == 0) begin : g_first
        assign l_data  = ctl.push_data;
        assign l_valid = 1'b1;
      end else begin : g_mid_l
        assign l_data  = cell_data[gi-1];
        assign l_valid = cell_valid[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_last
        assign r_data  = '0;
        assign r_valid = 1'b0;
      end else begin : g_mid_r
        assign r_data  = cell_data[gi+1];
        assign r_valid = cell_valid[gi+1];
      end

      dqc_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctl         (ctl),
        .left_data   (l_data),
        .left_valid  (l_valid),
        .right_data  (r_data),
        .right_valid (r_valid),
        .front_data  (cell_data[0]),
        .data        (cell_data[gi]),
        .valid       (cell_valid[gi])
      );
    end
  endgenerate

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;
  assign cmd      = cmd_t'(s_tuser);

  always_comb begin
    state_next      = state;
    count_next      = count;
    remain_next     = remain;
    ctl.op          = OP_HOLD;
    ctl.push_data   = s_tdata;
    load_out        = 1'b0;
    out_data_next   = '0;
    out_has_next    = 1'b0;
    out_status_next = ST_OK;
    out_last_next   = 1'b1;

    case (state)
      S_IDLE: begin
        if (accept) begin
          load_out = 1'b1;
          case (cmd)
            CMD_PUSH_FRONT: begin
              if (full) begin
                out_status_next = ST_FULL;
              end else begin
                ctl.op     = OP_PUSH_FRONT;
                count_next = count + CNT_W'(1);
              end
            end
            CMD_PUSH_BACK: begin
              if (full) begin
                out_status_next = ST_FULL;
              end else begin
                ctl.op     = OP_PUSH_BACK;
                count_next = count + CNT_W'(1);
              end
            end
            CMD_POP_FRONT: begin
              if (empty) begin
                out_status_next = ST_EMPTY;
              end else begin
                ctl.op     = OP_POP_FRONT;
                count_next = count - CNT_W'(1);
              end
            end
            CMD_POP_BACK: begin
              if (empty) begin
                out_status_next = ST_EMPTY;
              end else begin
                ctl.op     = OP_POP_BACK;
                count_next = count - CNT_W'(1);
              end
            end
            CMD_DUMP: begin
              // empty dump keeps the single no-value result loaded above
              if (!empty) begin
                load_out    = 1'b0;
                remain_next = count;
                state_next  = S_DUMP;
              end
            end
            default: begin
              // unused code: single all-zero result with last set
              load_out = 1'b1;
            end
          endcase
        end
      end
      S_DUMP: begin
        if (out_free) begin
          load_out      = 1'b1;
          out_data_next = cell_data[0];
          out_has_next  = 1'b1;
          out_last_next = (remain == CNT_W'(1));
          ctl.op        = OP_ROTATE;
          remain_next   = remain - CNT_W'(1);
          if (remain == CNT_W'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      remain   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      remain   <= remain_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data   <= out_data_next;
      out_has    <= out_has_next;
      out_status <= out_status_next;
      out_last   <= out_last_next;
    end
  end

  assign m_tdata = out_data;
  assign m_tuser = {out_status, out_has};
  assign m_tlast = out_last;

endmodule

[rtl/dqc_cell.sv]
// One storage cell of the deque chain: a value and an occupied bit.
// Depends on dqc_pkg.
module dqc_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  dqc_pkg::cell_ctl_t        ctl,
  input  logic [dqc_pkg::DATA_W-1:0] left_data,
  input  logic                      left_valid,
  input  logic [dqc_pkg::DATA_W-1:0] right_data,
  input  logic                      right_valid,
  input  logic [dqc_pkg::DATA_W-1:0] front_data,
  output logic [dqc_pkg::DATA_W-1:0] data,
  output logic                      valid
);
  import dqc_pkg::*;

  logic [DATA_W-1:0] data_next;
  logic              valid_next;
  logic              is_back;

  // back of the queue: occupied with an empty neighbor on the right
  assign is_back = valid && !right_valid;

  always_comb begin
    data_next  = data;
    valid_next = valid;
    case (ctl.op)
      OP_PUSH_FRONT: begin
        data_next  = left_data;
        valid_next = left_valid;
      end
      OP_PUSH_BACK: begin
        if (!valid && left_valid) begin
          data_next = ctl.push_data;
        end
        valid_next = left_valid;
      end
      OP_POP_FRONT: begin
        data_next  = right_data;
        valid_next = right_valid;
      end
      OP_POP_BACK: begin
        valid_next = right_valid;
      end
      OP_ROTATE: begin
        // occupied span turns by one; front wraps into the back cell
        data_next = is_back ? front_data : right_data;
      end
      default: begin
        data_next  = data;
        valid_next = valid;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

[rtl/dqc_checker.sv]
// Port-level checks for double_ended_queue_core, bound to the top level.
// Depends on dqc_pkg and double_ended_queue_core_macros.svh.
`include "double_ended_queue_core_macros.svh"

module dqc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [dqc_pkg::DATA_W-1:0]  m_tdata,
  input logic [dqc_pkg::STATUS_W:0]  m_tuser,
  input logic                        m_tlast
);
  import dqc_pkg::*;

  logic stall;
  logic has_value;

  assign stall     = m_tvalid && !m_tready;
  assign has_value = m_tuser[0];

  // stalled result holds
  `DQC_ASSERT(a_out_hold, clk, rst, stall |=> (m_tvalid && $stable({m_tdata, m_tuser, m_tlast})))
  // a waiting result blocks new input
  `DQC_ASSERT(a_stall_blocks, clk, rst, stall |-> !s_tready)
  // results without a stored value carry zero data and close their command
  `DQC_ASSERT(a_novalue_zero, clk, rst, (m_tvalid && !has_value) |-> (m_tdata == '0 && m_tlast))
  // dumped values always report ok
  `DQC_ASSERT(a_value_ok, clk, rst, (m_tvalid && has_value) |-> (m_tuser[2:1] == ST_OK))
  // reset empties the result register
  `DQC_ASSERT_ALWAYS(a_rst_idle, clk, rst |=> !m_tvalid)

endmodule

bind double_ended_queue_core dqc_checker u_dqc_checker (.*);
